// ===== rtl/core/lcdt_pkg.sv =====
// lcdt_pkg: shared types, constants and address decode for the lcd mode and line timer
// depends on nothing; imported by every module of the block
package lcdt_pkg;

    localparam int DOT_W        = 10;
    localparam int LINE_W       = 8;
    localparam int DATA_W       = 8;
    localparam int ADDR_W       = 16;
    localparam int TICK_W       = 8;

    localparam int DEF_LINE_DOTS     = 456;
    localparam int DEF_VISIBLE_LINES = 144;
    localparam int DEF_LAST_LINE     = 153;

    localparam logic [DOT_W-1:0] OAM_END  = DOT_W'(80);
    localparam logic [DOT_W-1:0] XFER_END = DOT_W'(252);

    // status register bits
    localparam int STAT_MATCH_BIT   = 2;
    localparam int STAT_HBL_EN_BIT  = 3;
    localparam int STAT_VBL_EN_BIT  = 4;
    localparam int STAT_OAM_EN_BIT  = 5;
    localparam int STAT_LYC_EN_BIT  = 6;
    localparam int STAT_WR_LSB      = 3;

    localparam logic [DATA_W-1:0] READ_UNMAPPED = 8'hFF;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        REG_LCDC,
        REG_STAT,
        REG_SCY,
        REG_SCX,
        REG_LY,
        REG_LYC,
        REG_BGP,
        REG_OBP0,
        REG_OBP1,
        REG_WY,
        REG_WX,
        REG_NONE
    } reg_sel_t;

    localparam logic [ADDR_W-1:0] ADDR_LCDC = 16'hFF40;
    localparam logic [ADDR_W-1:0] ADDR_STAT = 16'hFF41;
    localparam logic [ADDR_W-1:0] ADDR_SCY  = 16'hFF42;
    localparam logic [ADDR_W-1:0] ADDR_SCX  = 16'hFF43;
    localparam logic [ADDR_W-1:0] ADDR_LY   = 16'hFF44;
    localparam logic [ADDR_W-1:0] ADDR_LYC  = 16'hFF45;
    localparam logic [ADDR_W-1:0] ADDR_BGP  = 16'hFF47;
    localparam logic [ADDR_W-1:0] ADDR_OBP0 = 16'hFF48;
    localparam logic [ADDR_W-1:0] ADDR_OBP1 = 16'hFF49;
    localparam logic [ADDR_W-1:0] ADDR_WY   = 16'hFF4A;
    localparam logic [ADDR_W-1:0] ADDR_WX   = 16'hFF4B;

    // control from the top level to the timing unit
    typedef struct packed {
        logic              tick;
        logic              stat_wr;
        logic [TICK_W-1:0] dots;
        logic [DATA_W-1:0] wdata;
    } lcdt_tim_ctrl_t;

    // values after the item, as shown on the result channel
    typedef struct packed {
        logic [1:0]        mode;
        logic [LINE_W-1:0] line;
        logic              frame;
        logic              vblank_irq;
        logic              stat_irq;
        logic              line_render;
    } lcdt_tim_res_t;

    function automatic reg_sel_t reg_decode(input logic [ADDR_W-1:0] addr);
        reg_sel_t sel;
        sel = REG_NONE;
        unique case (addr)
            ADDR_LCDC: sel = REG_LCDC;
            ADDR_STAT: sel = REG_STAT;
            ADDR_SCY:  sel = REG_SCY;
            ADDR_SCX:  sel = REG_SCX;
            ADDR_LY:   sel = REG_LY;
            ADDR_LYC:  sel = REG_LYC;
            ADDR_BGP:  sel = REG_BGP;
            ADDR_OBP0: sel = REG_OBP0;
            ADDR_OBP1: sel = REG_OBP1;
            ADDR_WY:   sel = REG_WY;
            ADDR_WX:   sel = REG_WX;
            default:   sel = REG_NONE;
        endcase
        return sel;
    endfunction

endpackage

// ===== rtl/core/lcd_mode_and_line_timer.sv =====
// lcd_mode_and_line_timer: display mode and scanline timer with its lcd register file
// an accepted item sits in the input register and loads into the result register, where it is shown,
// once the result slot is free
// throughput: one item per cycle, set by the single-pass update; a stalled result holds the item
// in the input register and s_ready falls once both registers are full
// reset: aresetn synchronous active low; clears timing state, the lcd register file and both valid flags
// depends on lcdt_pkg, lcdt_regbank, lcdt_timing
module lcd_mode_and_line_timer
    import lcdt_pkg::*;
#(
    parameter int LINE_DOTS     = DEF_LINE_DOTS,
    parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
    parameter int LAST_LINE     = DEF_LAST_LINE
) (
    input  logic              aclk,
    input  logic              aresetn,
    // item channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  logic [TICK_W-1:0] s_tick_dots,
    input  logic [ADDR_W-1:0] s_reg_address,
    input  logic [DATA_W-1:0] s_write_data,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_read_data,
    output logic [1:0]        m_mode,
    output logic [LINE_W-1:0] m_current_line,
    output logic              m_vblank_irq,
    output logic              m_stat_irq,
    output logic              m_frame_ready,
    output logic              m_line_render
);

    // input register
    logic              in_valid_reg;
    logic [1:0]        cmd_reg;
    logic [TICK_W-1:0] dots_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] wdata_reg;

    // result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    lcdt_tim_res_t     res_reg;

    logic              out_free;
    logic              advance;
    reg_sel_t          sel;
    lcdt_tim_ctrl_t    tim_ctrl;
    lcdt_tim_res_t     tim_res;
    logic [DATA_W-1:0] status;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] lyc;
    logic [DATA_W-1:0] bank_rd;
    logic              is_read;
    logic              is_write;

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    // the held item moves to the result register, committing its state update
    assign advance  = in_valid_reg && out_free;
    // input register takes a new item whenever it is empty or empties this cycle
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_command;
            dots_reg  <= s_tick_dots;
            addr_reg  <= s_reg_address;
            wdata_reg <= s_write_data;
        end
    end

    // command decode; the unused code does nothing and yields zero pulses and read data
    assign is_read  = (cmd_reg == CMD_READ);
    assign is_write = (cmd_reg == CMD_WRITE);
    assign sel      = reg_decode(addr_reg);

    always_comb begin
        tim_ctrl.tick    = (cmd_reg == CMD_TICK);
        tim_ctrl.stat_wr = is_write && (sel == REG_STAT);
        tim_ctrl.dots    = dots_reg;
        tim_ctrl.wdata   = wdata_reg;
    end

    lcdt_timing #(
        .LINE_DOTS     (LINE_DOTS),
        .VISIBLE_LINES (VISIBLE_LINES),
        .LAST_LINE     (LAST_LINE)
    ) u_timing (
        .aclk    (aclk),
        .aresetn (aresetn),
        .commit  (advance),
        .ctrl    (tim_ctrl),
        .lyc     (lyc),
        .status  (status),
        .line    (line),
        .res     (tim_res)
    );

    // line register writes fall through as no-ops in the bank; status writes go to the timer
    lcdt_regbank u_regbank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (advance && is_write),
        .sel     (sel),
        .wdata   (wdata_reg),
        .status  (status),
        .line    (line),
        .lyc     (lyc),
        .rd_data (bank_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rdata_reg <= is_read ? bank_rd : '0;
            res_reg   <= tim_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = rdata_reg;
    assign m_mode         = res_reg.mode;
    assign m_current_line = res_reg.line;
    assign m_vblank_irq   = res_reg.vblank_irq;
    assign m_stat_irq     = res_reg.stat_irq;
    assign m_frame_ready  = res_reg.frame;
    assign m_line_render  = res_reg.line_render;

endmodule

// ===== rtl/core/lcdt_regbank.sv =====
// lcdt_regbank: lcd control, scroll, compare, palette and window registers plus the read mux
// depends on lcdt_pkg
module lcdt_regbank
    import lcdt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  reg_sel_t          sel,
    input  logic [DATA_W-1:0] wdata,
    input  logic [DATA_W-1:0] status,
    input  logic [LINE_W-1:0] line,
    output logic [LINE_W-1:0] lyc,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] lcdc_reg, scy_reg, scx_reg, lyc_reg;
    logic [DATA_W-1:0] bgp_reg, obp0_reg, obp1_reg, wy_reg, wx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcdc_reg <= '0;
            scy_reg  <= '0;
            scx_reg  <= '0;
            lyc_reg  <= '0;
            bgp_reg  <= '0;
            obp0_reg <= '0;
            obp1_reg <= '0;
            wy_reg   <= '0;
            wx_reg   <= '0;
        end else if (wr_en) begin
            unique case (sel)
                REG_LCDC: lcdc_reg <= wdata;
                REG_SCY:  scy_reg  <= wdata;
                REG_SCX:  scx_reg  <= wdata;
                REG_LYC:  lyc_reg  <= wdata;
                REG_BGP:  bgp_reg  <= wdata;
                REG_OBP0: obp0_reg <= wdata;
                REG_OBP1: obp1_reg <= wdata;
                REG_WY:   wy_reg   <= wdata;
                REG_WX:   wx_reg   <= wdata;
                default: ;
            endcase
        end
    end

    assign lyc = lyc_reg;

    always_comb begin
        unique case (sel)
            REG_LCDC: rd_data = lcdc_reg;
            REG_STAT: rd_data = status;
            REG_SCY:  rd_data = scy_reg;
            REG_SCX:  rd_data = scx_reg;
            REG_LY:   rd_data = line;
            REG_LYC:  rd_data = lyc_reg;
            REG_BGP:  rd_data = bgp_reg;
            REG_OBP0: rd_data = obp0_reg;
            REG_OBP1: rd_data = obp1_reg;
            REG_WY:   rd_data = wy_reg;
            REG_WX:   rd_data = wx_reg;
            default:  rd_data = READ_UNMAPPED;
        endcase
    end

endmodule

// ===== rtl/core/lcdt_timing.sv =====
// lcdt_timing: dot counter, scanline counter, status register, frame flag and irq pulses
// depends on lcdt_pkg
module lcdt_timing
    import lcdt_pkg::*;
#(
    parameter int LINE_DOTS     = DEF_LINE_DOTS,
    parameter int VISIBLE_LINES = DEF_VISIBLE_LINES,
    parameter int LAST_LINE     = DEF_LAST_LINE
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              commit,
    input  lcdt_tim_ctrl_t    ctrl,
    input  logic [LINE_W-1:0] lyc,
    output logic [DATA_W-1:0] status,
    output logic [LINE_W-1:0] line,
    output lcdt_tim_res_t     res
);

    localparam logic [DOT_W-1:0]  LINE_DOTS_C = DOT_W'(LINE_DOTS);
    localparam logic [LINE_W-1:0] VISIBLE_C   = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W:0]   LAST_C      = (LINE_W + 1)'(LAST_LINE);

    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [DATA_W-1:0] status_reg, status_next;
    logic              frame_reg, frame_next;

    logic [DOT_W-1:0]  dot_sum;
    logic [LINE_W:0]   line_inc, line_adv;
    logic              vb, st, rend;

    always_comb begin
        dot_sum     = dot_reg + DOT_W'(ctrl.dots);
        line_inc    = {1'b0, line_reg} + 1'b1;
        dot_next    = dot_reg;
        line_adv    = {1'b0, line_reg};
        line_next   = line_reg;
        status_next = status_reg;
        frame_next  = frame_reg;
        vb          = 1'b0;
        st          = 1'b0;
        rend        = 1'b0;
        if (ctrl.tick) begin
            // mode from dot position on visible lines
            if (line_reg < VISIBLE_C) begin
                if (dot_sum < OAM_END) begin
                    if (status_reg[1:0] != MODE_OAM) begin
                        status_next[1:0] = MODE_OAM;
                        st = status_reg[STAT_OAM_EN_BIT];
                    end
                end else if (dot_sum < XFER_END) begin
                    status_next[1:0] = MODE_XFER;
                end else if (dot_sum < LINE_DOTS_C) begin
                    if (status_reg[1:0] != MODE_HBLANK) begin
                        status_next[1:0] = MODE_HBLANK;
                        st   = status_reg[STAT_HBL_EN_BIT];
                        rend = (dot_reg < XFER_END);
                    end
                end
            end else if (status_reg[1:0] != MODE_VBLANK) begin
                status_next[1:0] = MODE_VBLANK;
                vb         = 1'b1;
                st         = status_reg[STAT_VBL_EN_BIT];
                frame_next = 1'b1;
            end
            // line end: one advance per tick at most
            if (dot_sum >= LINE_DOTS_C) begin
                dot_next = dot_sum - LINE_DOTS_C;
                line_adv = line_inc;
                if (line_inc == {1'b0, lyc}) begin
                    status_next[STAT_MATCH_BIT] = 1'b1;
                    if (status_reg[STAT_LYC_EN_BIT]) begin
                        st = 1'b1;
                    end
                end else begin
                    status_next[STAT_MATCH_BIT] = 1'b0;
                end
            end else begin
                dot_next = dot_sum;
            end
            if (line_adv > LAST_C) begin
                line_next  = '0;
                frame_next = 1'b0;
            end else begin
                line_next = line_adv[LINE_W-1:0];
            end
        end else if (ctrl.stat_wr) begin
            status_next = {ctrl.wdata[DATA_W-1:STAT_WR_LSB], status_reg[STAT_WR_LSB-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg    <= '0;
            line_reg   <= '0;
            status_reg <= '0;
            frame_reg  <= 1'b0;
        end else if (commit) begin
            dot_reg    <= dot_next;
            line_reg   <= line_next;
            status_reg <= status_next;
            frame_reg  <= frame_next;
        end
    end

    assign status = status_reg;
    assign line   = line_reg;

    always_comb begin
        res.mode        = status_next[1:0];
        res.line        = line_next;
        res.frame       = frame_next;
        res.vblank_irq  = vb;
        res.stat_irq    = st;
        res.line_render = rend;
    end

endmodule

// ===== rtl/core/lcdt_checker.sv =====
// lcdt_checker: port-level assertions for lcd_mode_and_line_timer, bound to the top level
// depends on lcdt_pkg and lcd_mode_and_line_timer
module lcdt_checker
    import lcdt_pkg::*;
#(
    parameter int LAST_LINE = DEF_LAST_LINE
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_read_data,
    input logic [1:0]        m_mode,
    input logic [LINE_W-1:0] m_current_line,
    input logic              m_vblank_irq,
    input logic              m_line_render
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_current_line))
        else $error("stalled result changed");

    // line never shown beyond the last line
    a_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_current_line} <= (LINE_W + 1)'(LAST_LINE)))
        else $error("line out of range");

    // vblank pulse only together with vblank mode
    a_vbl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_vblank_irq |-> m_mode == MODE_VBLANK)
        else $error("vblank pulse outside vblank");

    // render pulse only on entering hblank
    a_rend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_render |-> m_mode == MODE_HBLANK && !m_vblank_irq)
        else $error("render pulse outside hblank");

    // reset empties the result channel
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lcd_mode_and_line_timer lcdt_checker #(.LAST_LINE(LAST_LINE)) u_lcdt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_read_data    (m_read_data),
    .m_mode         (m_mode),
    .m_current_line (m_current_line),
    .m_vblank_irq   (m_vblank_irq),
    .m_line_render  (m_line_render)
);
